[design/plst_pkg.sv]
// Shared types, widths and codes of the positional list engine.
package plst_pkg;

  // Number of list entries the storage holds.
  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Fixed payload widths.
  localparam int CMD_W  = 2;
  localparam int POS_W  = 7;
  localparam int VAL_W  = 32;
  localparam int LEN_W  = 7;
  localparam int STAT_W = 2;

  // Width used to compare a requested position against the entry count.
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_UP   = 4'b0010,
    S_SCAN = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

endpackage

[design/plst_req_if.sv]
// Command channel of the positional list engine.
interface plst_req_if;
  logic                              valid;
  logic                              ready;
  logic [plst_pkg::CMD_W-1:0]        cmd;
  logic [plst_pkg::POS_W-1:0]        position;
  logic signed [plst_pkg::VAL_W-1:0] operand_value;

  modport source (output valid, output cmd, output position, output operand_value,
                  input ready);
  modport sink   (input valid, input cmd, input position, input operand_value,
                  output ready);
endinterface

[design/plst_rsp_if.sv]
// Result channel of the positional list engine.
interface plst_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [plst_pkg::VAL_W-1:0] result_value;
  logic                              found;
  logic [plst_pkg::LEN_W-1:0]        list_length;
  logic [plst_pkg::STAT_W-1:0]       status;

  modport source (output valid, output result_value, output found, output list_length,
                  output status, input ready);
  modport sink   (input valid, input result_value, input found, input list_length,
                  input status, output ready);
endinterface

[design/plst_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module plst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/positional_list_engine_top.sv]
// Top level of the positional list engine: command sequencer around the entry memory.
//
// The engine keeps an ordered list of up to DEPTH signed 32-bit entries in one
// single-port-write, single-port-read memory and a length register. Each command
// transfer on req yields exactly one result transfer on rsp carrying the fetched or
// removed entry, the search hit flag, the length after the command and a status
// (ok, bad position, list full). The memory moves one entry per cycle, so the cost
// of a command follows the number of entries it touches: an insert at position p
// shifts every entry from p to the end, a remove every entry above p, a get reads
// one entry and a search reads the whole list; a rejected command touches none.
// A new command is taken only when the previous one has finished all its memory
// writes, while its result may still wait in the output register for the consumer.
// The memory needs no clearing after reset: only entries below the length are ever
// read, and each was written.
module positional_list_engine_top (
  input logic            clk,
  input logic            rst,
  plst_req_if.sink       req,
  plst_rsp_if.source     rsp
);

  localparam int AW = plst_pkg::ADDR_W;
  localparam int CW = plst_pkg::CNT_W;

  plst_pkg::state_t  state, state_next;
  plst_pkg::cmd_t    op, op_next;
  plst_pkg::status_t stat, stat_next;

  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] lim, lim_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] ptr_dec;

  logic signed [plst_pkg::VAL_W-1:0] val, val_next;
  logic signed [plst_pkg::VAL_W-1:0] res, res_next;
  logic                              hit, hit_next;

  // A read was issued last cycle; its data is on mem_rdata now.
  logic          pend, pend_next;
  logic [AW-1:0] pend_addr, pend_addr_next;

  logic                              out_valid, out_valid_next;
  logic signed [plst_pkg::VAL_W-1:0] out_value, out_value_next;
  logic                              out_found, out_found_next;
  logic [plst_pkg::LEN_W-1:0]        out_len, out_len_next;
  logic [plst_pkg::STAT_W-1:0]       out_stat, out_stat_next;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [plst_pkg::VAL_W-1:0] mem_wdata;
  logic                       mem_re;
  logic [AW-1:0]              mem_raddr;
  logic [plst_pkg::VAL_W-1:0] mem_rdata;

  logic [plst_pkg::CMP_W-1:0] req_pos_ext;
  logic [plst_pkg::CMP_W-1:0] cnt_ext;

  plst_ram #(
    .WIDTH (plst_pkg::VAL_W),
    .DEPTH (plst_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign req.ready = (state == plst_pkg::S_IDLE);

  assign rsp.valid        = out_valid;
  assign rsp.result_value = out_value;
  assign rsp.found        = out_found;
  assign rsp.list_length  = out_len;
  assign rsp.status       = out_stat;

  assign req_pos_ext = plst_pkg::CMP_W'(req.position);
  assign cnt_ext     = plst_pkg::CMP_W'(cnt);
  assign ptr_dec     = ptr - CW'(1);

  always_comb begin
    state_next     = state;
    op_next        = op;
    stat_next      = stat;
    cnt_next       = cnt;
    ptr_next       = ptr;
    lim_next       = lim;
    pos_next       = pos;
    val_next       = val;
    res_next       = res;
    hit_next       = hit;
    pend_next      = 1'b0;
    pend_addr_next = pend_addr;

    out_valid_next = out_valid;
    out_value_next = out_value;
    out_found_next = out_found;
    out_len_next   = out_len;
    out_stat_next  = out_stat;

    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = mem_rdata;
    mem_re    = 1'b0;
    mem_raddr = ptr[AW-1:0];

    // The consumer took the waiting result.
    if (out_valid && rsp.ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      plst_pkg::S_IDLE: begin
        if (req.valid) begin
          op_next   = plst_pkg::cmd_t'(req.cmd);
          pos_next  = CW'(req.position);
          val_next  = req.operand_value;
          res_next  = '0;
          hit_next  = 1'b0;
          stat_next = plst_pkg::ST_OK;
          case (req.cmd)
            plst_pkg::CMD_INSERT: begin
              if (req_pos_ext > cnt_ext) begin
                stat_next  = plst_pkg::ST_BADPOS;
                state_next = plst_pkg::S_FIN;
              end else if (cnt == CW'(plst_pkg::DEPTH)) begin
                stat_next  = plst_pkg::ST_FULL;
                state_next = plst_pkg::S_FIN;
              end else begin
                ptr_next   = cnt;
                state_next = plst_pkg::S_UP;
              end
            end
            plst_pkg::CMD_REMOVE: begin
              if (req_pos_ext >= cnt_ext) begin
                stat_next  = plst_pkg::ST_BADPOS;
                state_next = plst_pkg::S_FIN;
              end else begin
                ptr_next   = CW'(req.position);
                lim_next   = cnt;
                state_next = plst_pkg::S_SCAN;
              end
            end
            plst_pkg::CMD_GET: begin
              if (req_pos_ext >= cnt_ext) begin
                stat_next  = plst_pkg::ST_BADPOS;
                state_next = plst_pkg::S_FIN;
              end else begin
                ptr_next   = CW'(req.position);
                lim_next   = CW'(req.position) + CW'(1);
                state_next = plst_pkg::S_SCAN;
              end
            end
            plst_pkg::CMD_SEARCH: begin
              ptr_next   = '0;
              lim_next   = cnt;
              state_next = plst_pkg::S_SCAN;
            end
            default: begin
              state_next = plst_pkg::S_FIN;
            end
          endcase
        end
      end

      // Shift entries up one place, from the top down to the insert position.
      plst_pkg::S_UP: begin
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr + AW'(1);
          mem_wdata = mem_rdata;
        end
        if (ptr > pos) begin
          mem_re         = 1'b1;
          mem_raddr      = ptr_dec[AW-1:0];
          pend_next      = 1'b1;
          pend_addr_next = ptr_dec[AW-1:0];
          ptr_next       = ptr_dec;
        end else if (!pend) begin
          // The write port is free again: place the new entry.
          mem_we     = 1'b1;
          mem_waddr  = pos[AW-1:0];
          mem_wdata  = val;
          cnt_next   = cnt + CW'(1);
          state_next = plst_pkg::S_FIN;
        end
      end

      // Ascending walk used by remove (read and shift down), get and search.
      plst_pkg::S_SCAN: begin
        if (pend) begin
          case (op)
            plst_pkg::CMD_REMOVE: begin
              if (pend_addr == pos[AW-1:0]) begin
                res_next = mem_rdata;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pend_addr - AW'(1);
                mem_wdata = mem_rdata;
              end
            end
            plst_pkg::CMD_GET: begin
              res_next = mem_rdata;
            end
            plst_pkg::CMD_SEARCH: begin
              if (mem_rdata == val) begin
                hit_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        if (ptr < lim) begin
          mem_re         = 1'b1;
          mem_raddr      = ptr[AW-1:0];
          pend_next      = 1'b1;
          pend_addr_next = ptr[AW-1:0];
          ptr_next       = ptr + CW'(1);
        end else if (!pend) begin
          if (op == plst_pkg::CMD_REMOVE) begin
            cnt_next = cnt - CW'(1);
          end
          state_next = plst_pkg::S_FIN;
        end
      end

      // Hand the result to the output register once it is free.
      plst_pkg::S_FIN: begin
        if (!out_valid || rsp.ready) begin
          out_valid_next = 1'b1;
          out_value_next = res;
          out_found_next = hit;
          out_len_next   = plst_pkg::LEN_W'(cnt);
          out_stat_next  = stat;
          state_next     = plst_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = plst_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= plst_pkg::S_IDLE;
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
    op        <= op_next;
    stat      <= stat_next;
    ptr       <= ptr_next;
    lim       <= lim_next;
    pos       <= pos_next;
    val       <= val_next;
    res       <= res_next;
    hit       <= hit_next;
    pend_addr <= pend_addr_next;
    out_value <= out_value_next;
    out_found <= out_found_next;
    out_len   <= out_len_next;
    out_stat  <= out_stat_next;
  end

endmodule

[design/plst_checker.sv]
// Port-level assertions for the positional list engine and their bind.
module plst_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic signed [plst_pkg::VAL_W-1:0] rsp_result_value,
  input logic                              rsp_found,
  input logic [plst_pkg::LEN_W-1:0]        rsp_list_length,
  input logic [plst_pkg::STAT_W-1:0]       rsp_status
);

  // A full-list rejection can only be reported when the list is at capacity.
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status == plst_pkg::ST_FULL) |->
      (rsp_list_length == plst_pkg::LEN_W'(plst_pkg::DEPTH)))
    else $error("list full reported below capacity");

  // A rejected command returns no data and no hit.
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != plst_pkg::ST_OK) |->
      (rsp_result_value == '0) && !rsp_found)
    else $error("rejected command carries data");

  // A search hit never comes with a non-ok status or a nonempty data field.
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_found |->
      (rsp_status == plst_pkg::ST_OK) && (rsp_result_value == '0) &&
      (rsp_list_length != '0))
    else $error("search hit with inconsistent fields");

  // A stalled result holds its data.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_value) &&
      $stable(rsp_list_length) && $stable(rsp_status))
    else $error("stalled result changed");

endmodule

bind positional_list_engine_top plst_checker u_plst_checker (
  .clk              (clk),
  .rst              (rst),
  .rsp_valid        (rsp.valid),
  .rsp_ready        (rsp.ready),
  .rsp_result_value (rsp.result_value),
  .rsp_found        (rsp.found),
  .rsp_list_length  (rsp.list_length),
  .rsp_status       (rsp.status)
);

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the positional list engine: directed table, then random traffic.
module tb_top;
  import plst_pkg::*;

  // Extreme operand values, used by the directed table and the random value mix.
  localparam logic signed [VAL_W-1:0] VMIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VMAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VNEG1 = 32'shFFFF_FFFF;

  // Random traffic is split into phases that push the list toward growth,
  // shrinkage or a balance, so that it runs into the full and the empty list
  // many times. The tail of the run is driven with no idling at all.
  localparam int RANDOM_ITEMS = 1850;
  localparam int PHASE_LEN    = 160;
  localparam int TAIL_ITEMS   = 150;
  localparam int NUM_DIRECTED = 24;

  // One result of the engine, as the predictor computes it.
  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    found;
    logic [LEN_W-1:0]        length;
    status_t                 status;
  } list_result_t;

  // One row of the directed table. When has_want is set, the expected result
  // is the one typed into the row; otherwise the predictor supplies it.
  typedef struct packed {
    cmd_t                    op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] operand;
    logic                    has_want;
    list_result_t            want;
  } stim_row_t;

  logic clk;
  logic rst;

  plst_req_if req_ch ();
  plst_rsp_if rsp_ch ();

  positional_list_engine_top DUT (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the list that the predictor keeps in step with the engine.
  logic signed [VAL_W-1:0] shadow_entries [DEPTH];
  int                      shadow_count;

  // Results still owed by the engine, oldest first.
  list_result_t pending_list_results [$];

  // Run bookkeeping.
  int  mismatch_count;
  int  commands_sent;
  int  results_seen;
  int  full_refusals;
  int  position_refusals;
  int  search_hits;
  int  longest_list;
  bit  sender_gaps_on;
  bit  quiet_tail;

  // The directed table walks through the empty list, the value extremes,
  // every command, bad positions at both ends of the position field, and a
  // search that ignores its position. Rows whose answer is obvious carry it.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // Empty list: get, remove and an insert past the end are all refused.
    '{CMD_GET,    7'd0,   32'sd0,  1'b1, '{32'sd0, 1'b0, 7'd0, ST_BADPOS}},
    '{CMD_REMOVE, 7'd0,   32'sd0,  1'b1, '{32'sd0, 1'b0, 7'd0, ST_BADPOS}},
    '{CMD_SEARCH, 7'd0,   32'sd0,  1'b1, '{32'sd0, 1'b0, 7'd0, ST_OK}},
    '{CMD_INSERT, 7'd1,   32'sd5,  1'b1, '{32'sd0, 1'b0, 7'd0, ST_BADPOS}},
    '{CMD_INSERT, 7'd127, VNEG1,   1'b1, '{32'sd0, 1'b0, 7'd0, ST_BADPOS}},
    // Build the list 0, MIN, -1, MAX with inserts at the front, middle and end.
    '{CMD_INSERT, 7'd0,   VMIN,    1'b1, '{32'sd0, 1'b0, 7'd1, ST_OK}},
    '{CMD_INSERT, 7'd1,   VMAX,    1'b1, '{32'sd0, 1'b0, 7'd2, ST_OK}},
    '{CMD_INSERT, 7'd1,   VNEG1,   1'b1, '{32'sd0, 1'b0, 7'd3, ST_OK}},
    '{CMD_INSERT, 7'd0,   32'sd0,  1'b1, '{32'sd0, 1'b0, 7'd4, ST_OK}},
    '{CMD_GET,    7'd0,   32'sd0,  1'b1, '{32'sd0, 1'b0, 7'd4, ST_OK}},
    '{CMD_GET,    7'd1,   32'sd0,  1'b1, '{VMIN,   1'b0, 7'd4, ST_OK}},
    '{CMD_GET,    7'd3,   VMAX,    1'b1, '{VMAX,   1'b0, 7'd4, ST_OK}},
    '{CMD_GET,    7'd4,   32'sd0,  1'b1, '{32'sd0, 1'b0, 7'd4, ST_BADPOS}},
    '{CMD_GET,    7'd127, 32'sd0,  1'b1, '{32'sd0, 1'b0, 7'd4, ST_BADPOS}},
    '{CMD_SEARCH, 7'd0,   VMAX,    1'b1, '{32'sd0, 1'b1, 7'd4, ST_OK}},
    '{CMD_SEARCH, 7'd0,   VMIN,    1'b1, '{32'sd0, 1'b1, 7'd4, ST_OK}},
    '{CMD_SEARCH, 7'd0,   32'sd1,  1'b1, '{32'sd0, 1'b0, 7'd4, ST_OK}},
    '{CMD_SEARCH, 7'd127, 32'sd0,  1'b0, '0},
    // Removes: past the end, from the middle, then the last entry.
    '{CMD_REMOVE, 7'd4,   32'sd0,  1'b1, '{32'sd0, 1'b0, 7'd4, ST_BADPOS}},
    '{CMD_REMOVE, 7'd1,   32'sd0,  1'b1, '{VMIN,   1'b0, 7'd3, ST_OK}},
    '{CMD_REMOVE, 7'd2,   32'sd0,  1'b1, '{VMAX,   1'b0, 7'd2, ST_OK}},
    '{CMD_INSERT, 7'd2,   32'sh5A5A_5A5A, 1'b0, '0},
    '{CMD_REMOVE, 7'd0,   VNEG1,   1'b0, '0},
    '{CMD_INSERT, 7'd0,   32'sh1234_5678, 1'b0, '0}
  };

  // Works out the result of one command on the shadow list and updates it.
  function automatic list_result_t apply_list_command(cmd_t op, logic [POS_W-1:0] pos,
                                                      logic signed [VAL_W-1:0] operand);
    list_result_t r;
    int           p;
    r        = '0;
    r.status = ST_OK;
    p        = int'(pos);
    case (op)
      CMD_INSERT: begin
        // A bad position is reported ahead of a full list.
        if (p > shadow_count) begin
          r.status = ST_BADPOS;
        end else if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = shadow_count; i > p; i--) shadow_entries[i] = shadow_entries[i-1];
          shadow_entries[p] = operand;
          shadow_count++;
        end
      end
      CMD_REMOVE: begin
        if (p >= shadow_count) begin
          r.status = ST_BADPOS;
        end else begin
          r.value = shadow_entries[p];
          for (int i = p; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
          shadow_count--;
        end
      end
      CMD_GET: begin
        if (p >= shadow_count) r.status = ST_BADPOS;
        else r.value = shadow_entries[p];
      end
      default: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_entries[i] == operand) begin
            r.found = 1'b1;
            break;
          end
        end
      end
    endcase
    r.length = shadow_count[LEN_W-1:0];
    return r;
  endfunction

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(string what, longint want_v, longint got_v);
    mismatch_count++;
    $display("[%0t] ERROR %s: expected %0d, got %0d", $time, what, want_v, got_v);
  endtask

  // Compares the result on the bus with the oldest outstanding expectation.
  task automatic check_list_result();
    list_result_t want;
    if (pending_list_results.size() == 0) begin
      report_mismatch("result with nothing outstanding, list_length", -1, rsp_ch.list_length);
      return;
    end
    want = pending_list_results.pop_front();
    results_seen++;
    if (rsp_ch.result_value !== want.value)
      report_mismatch("result_value", want.value, rsp_ch.result_value);
    if (rsp_ch.found !== want.found)
      report_mismatch("found", want.found, rsp_ch.found);
    if (rsp_ch.list_length !== want.length)
      report_mismatch("list_length", want.length, rsp_ch.list_length);
    if (rsp_ch.status !== want.status)
      report_mismatch("status", want.status, rsp_ch.status);
    if (want.status == ST_FULL) full_refusals++;
    if (want.status == ST_BADPOS) position_refusals++;
    if (want.found) search_hits++;
    if (want.length > longest_list) longest_list = want.length;
  endtask

  // Presents one command, holds it until the engine takes it, then records the
  // expected result. Valid is left high so that back-to-back commands need no
  // gap; callers that want a gap lower it through idle_sender.
  task automatic issue_command(cmd_t op, logic [POS_W-1:0] pos,
                               logic signed [VAL_W-1:0] operand,
                               bit has_want, list_result_t want);
    list_result_t predicted;
    req_ch.valid         <= 1'b1;
    req_ch.cmd           <= op;
    req_ch.position      <= pos;
    req_ch.operand_value <= operand;
    do @(posedge clk); while (!req_ch.ready);
    predicted = apply_list_command(op, pos, operand);
    pending_list_results.push_back(has_want ? want : predicted);
    commands_sent++;
  endtask

  task automatic idle_sender(int cycles);
    req_ch.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Holds the command side off until the engine has returned every result.
  task automatic hold_until_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_list_results.size() != 0) @(posedge clk);
  endtask

  // A gap of random length in front of a command, now and then.
  task automatic maybe_gap();
    if (sender_gaps_on && !quiet_tail && $urandom_range(0, 4) == 0)
      idle_sender($urandom_range(1, 16));
  endtask

  // Operand mix: extremes, a narrow range that makes duplicates likely,
  // copies of stored entries so searches hit, and full-range values.
  function automatic logic signed [VAL_W-1:0] pick_operand();
    int sel;
    sel = $urandom_range(0, 15);
    case (sel)
      0: return VMIN;
      1: return VMAX;
      2: return 32'sd0;
      3: return VNEG1;
      4, 5, 6, 7: return $signed($urandom_range(0, 16)) - 8;
      8, 9, 10: begin
        if (shadow_count > 0) return shadow_entries[$urandom_range(0, shadow_count - 1)];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal positions, with a bias toward both ends of the list, and
  // now and then anything the field can hold.
  function automatic logic [POS_W-1:0] pick_position(cmd_t op);
    int last;
    if (op == CMD_SEARCH || $urandom_range(0, 9) == 0) return POS_W'($urandom_range(0, 127));
    last = (op == CMD_INSERT) ? shadow_count : shadow_count - 1;
    if (last < 0) return POS_W'($urandom_range(0, 3));
    case ($urandom_range(0, 5))
      0: return '0;
      1: return POS_W'(last);
      default: return POS_W'($urandom_range(0, last));
    endcase
  endfunction

  function automatic cmd_t pick_command(int insert_pct, int remove_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < insert_pct) return CMD_INSERT;
    if (roll < insert_pct + remove_pct) return CMD_REMOVE;
    if (roll < insert_pct + remove_pct + (100 - insert_pct - remove_pct) / 2) return CMD_GET;
    return CMD_SEARCH;
  endfunction

  // Clock: 12 ns period.
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the engine hangs. The slowest legal run is about
  // 2000 commands, some 2.4 ms; this allows several times that.
  initial begin
    #20_000_000;
    $display("positional_list_engine_top: mismatch");
    $finish;
  end

  // Result side: ready is withdrawn in bursts of random length. The
  // bursts switch on and off now and then, so there are long stretches with
  // ready held high, and none at all once the quiet tail starts.
  initial begin
    int stall_left;
    bit stalls_on;
    stall_left   = 0;
    stalls_on    = 1'b1;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 399) == 0) stalls_on = !stalls_on;
      if (quiet_tail) begin
        rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 15);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Result monitor. Outputs are read right at the edge, before any update
  // made at that edge takes effect, so a transfer is seen exactly once.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) check_list_result();
  end

  // Main sequence: reset, directed table, fill to capacity, random phases,
  // drain and verdict.
  initial begin
    int   insert_pct;
    int   remove_pct;
    cmd_t op;

    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.cmd           = CMD_INSERT;
    req_ch.position      = '0;
    req_ch.operand_value = '0;
    shadow_count         = 0;
    mismatch_count       = 0;
    commands_sent        = 0;
    results_seen         = 0;
    full_refusals        = 0;
    position_refusals    = 0;
    search_hits          = 0;
    longest_list         = 0;
    sender_gaps_on       = 1'b1;
    quiet_tail           = 1'b0;
    insert_pct           = 35;
    remove_pct           = 35;
    for (int i = 0; i < DEPTH; i++) shadow_entries[i] = '0;

    // Reset is held, then released at a clock edge.
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    foreach (directed_rows[i]) begin
      maybe_gap();
      issue_command(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].operand,
                    directed_rows[i].has_want, directed_rows[i].want);
    end

    // Fill the list to capacity with inserts at random legal positions, then
    // probe the full list: inserts at the end and the front are refused as
    // full, one past the end as a bad position, and the last entry is read
    // and removed.
    while (shadow_count < DEPTH) begin
      maybe_gap();
      issue_command(CMD_INSERT, POS_W'($urandom_range(0, shadow_count)), pick_operand(),
                    1'b0, '0);
    end
    issue_command(CMD_INSERT, POS_W'(DEPTH), pick_operand(), 1'b0, '0);
    issue_command(CMD_INSERT, '0, pick_operand(), 1'b0, '0);
    issue_command(CMD_INSERT, POS_W'(DEPTH + 1), pick_operand(), 1'b0, '0);
    issue_command(CMD_INSERT, POS_W'(127), pick_operand(), 1'b0, '0);
    issue_command(CMD_SEARCH, '0, pick_operand(), 1'b0, '0);
    issue_command(CMD_GET, POS_W'(DEPTH - 1), '0, 1'b0, '0);
    issue_command(CMD_GET, POS_W'(DEPTH), '0, 1'b0, '0);
    issue_command(CMD_REMOVE, POS_W'(DEPTH), '0, 1'b0, '0);
    issue_command(CMD_REMOVE, POS_W'(DEPTH - 1), '0, 1'b0, '0);

    // The sender waits here until every outstanding result is back.
    hold_until_drained();

    // Random phases. Each phase picks a growth, shrink or balanced mix and
    // decides whether the sender inserts gaps. Every third boundary the
    // sender also waits for the engine to drain completely, except in the
    // quiet tail.
    for (int item = 0; item < RANDOM_ITEMS; item++) begin
      if (item % PHASE_LEN == 0) begin
        case ((item / PHASE_LEN) % 3)
          0: begin insert_pct = 55; remove_pct = 15; end
          1: begin insert_pct = 15; remove_pct = 55; end
          default: begin insert_pct = 35; remove_pct = 35; end
        endcase
        sender_gaps_on = ($urandom_range(0, 3) != 0);
        if (item > 0 && (item / PHASE_LEN) % 3 == 2 && !quiet_tail) hold_until_drained();
      end
      if (item == RANDOM_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
      maybe_gap();
      op = pick_command(insert_pct, remove_pct);
      issue_command(op, pick_position(op), pick_operand(), 1'b0, '0);
    end

    // Drain: wait for every result, then keep clocking for anything stray to show up.
    req_ch.valid <= 1'b0;
    while (pending_list_results.size() != 0) @(posedge clk);
    repeat (DEPTH + 16) @(posedge clk);

    $display("Ran %0d commands, checked %0d results; longest list %0d of %0d.",
             commands_sent, results_seen, longest_list, DEPTH);
    $display("Refusals: %0d full list, %0d bad position; %0d search hits.",
             full_refusals, position_refusals, search_hits);
    if (mismatch_count == 0) begin
      $display("positional_list_engine_top: match");
    end else begin
      $display("positional_list_engine_top: mismatch");
    end
    $finish;
  end

endmodule
